### rtl/brs_pkg.sv
// Bilinear RGB sampler: shared widths, types and register codes.
// No dependencies; every other file but brs_ram refers to this package by scoped names.
package brs_pkg;

    localparam int CHAN_W  = 8;
    localparam int COORD_W = 8;
    localparam int POS_W   = 16;
    localparam int SIZE_W  = 9;
    localparam int APB_AW  = 3;
    localparam int APB_DW  = 32;

    typedef logic [CHAN_W-1:0]  t_chan;
    typedef logic [COORD_W-1:0] t_coord;
    typedef logic [POS_W-1:0]   t_pos;
    typedef logic [SIZE_W-1:0]  t_size;

    // register index, taken from paddr bit 2
    localparam logic REG_WIDTH  = 1'b0;
    localparam logic REG_HEIGHT = 1'b1;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SAMPLE = 1'b1;

endpackage

### rtl/brs_if.sv
// Valid/ready channels of the sampler: request word in, RGB result word out.
// Depends on brs_pkg for field types.
interface brs_in_if;
    logic            valid;
    logic            ready;
    logic            req_type;
    brs_pkg::t_coord pixel_col;
    brs_pkg::t_coord pixel_row;
    brs_pkg::t_chan  in_red;
    brs_pkg::t_chan  in_green;
    brs_pkg::t_chan  in_blue;
    brs_pkg::t_pos   x_pos;
    brs_pkg::t_pos   y_pos;

    modport source (output valid, req_type, pixel_col, pixel_row, in_red, in_green,
                    in_blue, x_pos, y_pos, input ready);
    modport sink   (input valid, req_type, pixel_col, pixel_row, in_red, in_green,
                    in_blue, x_pos, y_pos, output ready);
endinterface

interface brs_out_if;
    logic           valid;
    logic           ready;
    brs_pkg::t_chan out_red;
    brs_pkg::t_chan out_green;
    brs_pkg::t_chan out_blue;

    modport source (output valid, out_red, out_green, out_blue, input ready);
    modport sink   (input valid, out_red, out_green, out_blue, output ready);
endinterface

### rtl/brs_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module brs_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16384
) (
    input  logic                                      i_clk,
    input  logic                                      i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                          i_wdata,
    input  logic                                      i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                          o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/brs_lane.sv
// One color channel of the blend: x blend, register, y blend with rounding, register.
// Depends on brs_pkg for the channel type.
module brs_lane #(
    parameter int FRAC_BITS = 8
) (
    input  logic                 i_clk,
    input  logic                 i_adv,
    input  brs_pkg::t_chan       i_a,
    input  brs_pkg::t_chan       i_b,
    input  brs_pkg::t_chan       i_d,
    input  brs_pkg::t_chan       i_e,
    input  logic [FRAC_BITS-1:0] i_fx,
    input  logic [FRAC_BITS-1:0] i_fy,
    output brs_pkg::t_chan       o_val
);

    localparam int SW = FRAC_BITS + 1;
    localparam int HW = brs_pkg::CHAN_W + FRAC_BITS;
    localparam int VW = brs_pkg::CHAN_W + 2 * FRAC_BITS;
    localparam logic [SW-1:0] SCALE = SW'(1) << FRAC_BITS;
    localparam logic [VW-1:0] HALF  = VW'(1) << (2 * FRAC_BITS - 1);

    logic [SW-1:0]        wx;
    logic [SW-1:0]        wy;
    logic [HW:0]          top_sum;
    logic [HW:0]          bot_sum;
    logic [HW-1:0]        n_top;
    logic [HW-1:0]        n_bot;
    logic [HW-1:0]        r_top;
    logic [HW-1:0]        r_bot;
    logic [FRAC_BITS-1:0] r_fy;
    logic [VW-1:0]        v_sum;
    brs_pkg::t_chan       r_val;

    assign wx      = SCALE - SW'(i_fx);
    assign top_sum = (HW+1)'(i_a) * (HW+1)'(wx) + (HW+1)'(i_b) * (HW+1)'(i_fx);
    assign bot_sum = (HW+1)'(i_d) * (HW+1)'(wx) + (HW+1)'(i_e) * (HW+1)'(i_fx);
    // both sums stay below 256 * SCALE
    assign n_top   = top_sum[HW-1:0];
    assign n_bot   = bot_sum[HW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_top <= n_top;
            r_bot <= n_bot;
            r_fy  <= i_fy;
        end
    end

    assign wy    = SCALE - SW'(r_fy);
    assign v_sum = VW'(r_top) * VW'(wy) + VW'(r_bot) * VW'(r_fy) + HALF;

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_val <= v_sum[VW-1:2*FRAC_BITS];
        end
    end

    assign o_val = r_val;

endmodule

### rtl/bilinear_rgb_sampler_top.sv
// Bilinear RGB sampler top level: pixel store banks, coordinate clamp, lanes, result word.
// Depends on brs_pkg, brs_if (brs_in_if, brs_out_if), brs_ram and brs_lane.
//
// The block takes one word per clock whenever its result register is free or being
// taken. A write word stores its pixel in the same cycle and returns nothing. A sample
// word returns its RGB result after a registered read of the four neighbours, then a
// registered x blend and y blend with rounding in the three channel lanes. The store
// is split into four banks by column and row parity, so the 2x2 neighbourhood is
// read together. Whenever the result register holds a word that is not taken, the
// whole pipeline and the input hold. The store is not cleared at reset: read only
// pixels that were written. Size registers are written over APB at byte addresses 0
// (width) and 4 (height), by the user only while idle; the block does not enforce it.
module bilinear_rgb_sampler_top #(
    parameter int IMG_COLS  = 256,
    parameter int IMG_ROWS  = 256,
    parameter int FRAC_BITS = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    brs_in_if.sink                      i_in,
    brs_out_if.source                   o_out,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [brs_pkg::APB_AW-1:0]  paddr,
    input  logic [brs_pkg::APB_DW-1:0]  pwdata,
    output logic [brs_pkg::APB_DW-1:0]  prdata,
    output logic                        pready
);

    localparam int CW    = $clog2(IMG_COLS);
    localparam int RW    = $clog2(IMG_ROWS);
    localparam int HC    = (IMG_COLS + 1) / 2;
    localparam int HR    = (IMG_ROWS + 1) / 2;
    localparam int DEPTH = HC * HR;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int PXW   = 3 * brs_pkg::CHAN_W;
    localparam int IW    = brs_pkg::POS_W + 1;

    function automatic int last_idx(input brs_pkg::t_size v, input int lim);
        int r;
        if (v == '0) begin
            r = 0;
        end else if (int'(v) > lim) begin
            r = lim - 1;
        end else begin
            r = int'(v) - 1;
        end
        return r;
    endfunction

    function automatic logic [AW-1:0] bank_addr(input logic [CW-1:0] col,
                                                input logic [RW-1:0] row);
        logic [CW-1:0] ch;
        logic [RW-1:0] rh;
        ch = col >> 1;
        rh = row >> 1;
        return AW'(rh) * AW'(HC) + AW'(ch);
    endfunction

    // ---------------- configuration ----------------
    brs_pkg::t_size r_width;
    brs_pkg::t_size r_height;
    logic [CW-1:0]  r_last_c;
    logic [RW-1:0]  r_last_r;
    logic           cfg_wr;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= brs_pkg::SIZE_W'(256);
            r_height <= brs_pkg::SIZE_W'(256);
            r_last_c <= CW'(last_idx(brs_pkg::SIZE_W'(256), IMG_COLS));
            r_last_r <= RW'(last_idx(brs_pkg::SIZE_W'(256), IMG_ROWS));
        end else if (cfg_wr) begin
            unique case (paddr[2])
                brs_pkg::REG_WIDTH: begin
                    r_width  <= pwdata[brs_pkg::SIZE_W-1:0];
                    r_last_c <= CW'(last_idx(pwdata[brs_pkg::SIZE_W-1:0], IMG_COLS));
                end
                brs_pkg::REG_HEIGHT: begin
                    r_height <= pwdata[brs_pkg::SIZE_W-1:0];
                    r_last_r <= RW'(last_idx(pwdata[brs_pkg::SIZE_W-1:0], IMG_ROWS));
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            brs_pkg::REG_WIDTH:  prdata = brs_pkg::APB_DW'(r_width);
            brs_pkg::REG_HEIGHT: prdata = brs_pkg::APB_DW'(r_height);
        endcase
    end

    // ---------------- handshake and pipeline control ----------------
    logic r_v1;
    logic r_v2;
    logic r_v3;
    logic adv;
    logic acc;

    // advance everything unless the result word is stuck
    assign adv        = !r_v3 || o_out.ready;
    assign i_in.ready = adv;
    assign acc        = i_in.valid && adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (adv) begin
            r_v1 <= acc && (i_in.req_type == brs_pkg::REQ_SAMPLE);
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // ---------------- write path ----------------
    logic [CW-1:0]  wcol;
    logic [RW-1:0]  wrow;
    logic           wr_ok;
    logic [AW-1:0]  waddr;
    logic [PXW-1:0] wdata;

    assign wcol  = CW'(i_in.pixel_col);
    assign wrow  = RW'(i_in.pixel_row);
    assign wr_ok = acc && (i_in.req_type == brs_pkg::REQ_WRITE)
                   && (int'(i_in.pixel_col) < IMG_COLS)
                   && (int'(i_in.pixel_row) < IMG_ROWS);
    assign waddr = bank_addr(wcol, wrow);
    assign wdata = {i_in.in_red, i_in.in_green, i_in.in_blue};

    // ---------------- sample coordinates ----------------
    logic [IW-1:0]        cx;
    logic [IW-1:0]        cx1;
    logic [IW-1:0]        ry;
    logic [IW-1:0]        ry1;
    logic [CW-1:0]        c0;
    logic [CW-1:0]        c1;
    logic [RW-1:0]        r0;
    logic [RW-1:0]        r1;
    logic [FRAC_BITS-1:0] fx;
    logic [FRAC_BITS-1:0] fy;

    assign cx  = IW'(i_in.x_pos) >> FRAC_BITS;
    assign ry  = IW'(i_in.y_pos) >> FRAC_BITS;
    assign cx1 = cx + IW'(1);
    assign ry1 = ry + IW'(1);
    assign c0  = (cx  > IW'(r_last_c)) ? r_last_c : CW'(cx);
    assign c1  = (cx1 > IW'(r_last_c)) ? r_last_c : CW'(cx1);
    assign r0  = (ry  > IW'(r_last_r)) ? r_last_r : RW'(ry);
    assign r1  = (ry1 > IW'(r_last_r)) ? r_last_r : RW'(ry1);
    assign fx  = i_in.x_pos[FRAC_BITS-1:0];
    assign fy  = i_in.y_pos[FRAC_BITS-1:0];

    // ---------------- parity banks: index is {row parity, column parity} ----------------
    logic [PXW-1:0] rdata [4];

    for (genvar k = 0; k < 4; k++) begin : g_bank
        localparam logic KC = 1'(k % 2);
        localparam logic KR = 1'(k / 2);

        logic [CW-1:0] bcol;
        logic [RW-1:0] brow;

        // pick whichever neighbour column and row have this bank's parity
        assign bcol = (c0[0] == KC) ? c0 : c1;
        assign brow = (r0[0] == KR) ? r0 : r1;

        brs_ram #(
            .WIDTH (PXW),
            .DEPTH (DEPTH)
        ) u_bank (
            .i_clk   (i_clk),
            .i_we    (wr_ok && (wcol[0] == KC) && (wrow[0] == KR)),
            .i_waddr (waddr),
            .i_wdata (wdata),
            .i_re    (adv),
            .i_raddr (bank_addr(bcol, brow)),
            .o_rdata (rdata[k])
        );
    end

    logic                 r_c0p;
    logic                 r_c1p;
    logic                 r_r0p;
    logic                 r_r1p;
    logic [FRAC_BITS-1:0] r_fx;
    logic [FRAC_BITS-1:0] r_fy;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_c0p <= c0[0];
            r_c1p <= c1[0];
            r_r0p <= r0[0];
            r_r1p <= r1[0];
            r_fx  <= fx;
            r_fy  <= fy;
        end
    end

    logic [PXW-1:0] p00;
    logic [PXW-1:0] p10;
    logic [PXW-1:0] p01;
    logic [PXW-1:0] p11;

    assign p00 = rdata[{r_r0p, r_c0p}];
    assign p10 = rdata[{r_r0p, r_c1p}];
    assign p01 = rdata[{r_r1p, r_c0p}];
    assign p11 = rdata[{r_r1p, r_c1p}];

    // ---------------- channel lanes; lane 0 is red ----------------
    brs_pkg::t_chan lane_val [3];

    for (genvar ch = 0; ch < 3; ch++) begin : g_lane
        localparam int LO = (2 - ch) * brs_pkg::CHAN_W;

        brs_lane #(
            .FRAC_BITS (FRAC_BITS)
        ) u_lane (
            .i_clk (i_clk),
            .i_adv (adv),
            .i_a   (p00[LO +: brs_pkg::CHAN_W]),
            .i_b   (p10[LO +: brs_pkg::CHAN_W]),
            .i_d   (p01[LO +: brs_pkg::CHAN_W]),
            .i_e   (p11[LO +: brs_pkg::CHAN_W]),
            .i_fx  (r_fx),
            .i_fy  (r_fy),
            .o_val (lane_val[ch])
        );
    end

    // merge the lane registers into the result word
    assign o_out.valid     = r_v3;
    assign o_out.out_red   = lane_val[0];
    assign o_out.out_green = lane_val[1];
    assign o_out.out_blue  = lane_val[2];

endmodule

### rtl/brs_checker.sv
// Port-level checks for the bilinear RGB sampler, bound to its top level.
// Depends on brs_pkg and on the port names of bilinear_rgb_sampler_top.
module brs_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input brs_pkg::t_chan i_out_red,
    input brs_pkg::t_chan i_out_green,
    input brs_pkg::t_chan i_out_blue
);

    // reset empties the result register
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result word present after reset");

    // an empty result register never holds back the input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty result register");

    // a stuck result word stalls the input
    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |-> !i_in_ready)
        else $error("input taken while result word stuck");

    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_out_red) && $stable(i_out_green)
             && $stable(i_out_blue)))
        else $error("stalled result word changed");

endmodule

bind bilinear_rgb_sampler_top brs_checker u_brs_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_red   (o_out.out_red),
    .i_out_green (o_out.out_green),
    .i_out_blue  (o_out.out_blue)
);

### tb/bilinear_rgb_sampler_top_tb.sv
`timescale 1ns / 100ps
// Testbench for bilinear_rgb_sampler_top: pixel writes and bilinear samples over the
// valid/ready channels, image size over APB, every result word checked against a local blend.
// Depends on brs_pkg, brs_if (brs_in_if, brs_out_if) and the sampler RTL.
module bilinear_rgb_sampler_top_tb;

    localparam int IMG_COLS     = 256;
    localparam int IMG_ROWS     = 256;
    localparam int FRAC_BITS    = 8;
    localparam int SCALE        = 1 << FRAC_BITS;
    localparam int HALF_LSB     = 1 << (2 * FRAC_BITS - 1);
    localparam int CLK_HALF     = 5;
    localparam int RESET_CYCLES = 6;
    localparam int PIPE_DEPTH   = 3;
    localparam int STUCK_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_WORDS = 1300;
    localparam int PHASES       = 8;

    typedef struct packed {
        brs_pkg::t_chan red;
        brs_pkg::t_chan green;
        brs_pkg::t_chan blue;
    } t_rgb;

    typedef struct packed {
        logic            req_type;
        brs_pkg::t_coord pixel_col;
        brs_pkg::t_coord pixel_row;
        t_rgb            pix;
        brs_pkg::t_pos   x_pos;
        brs_pkg::t_pos   y_pos;
    } t_req_word;

    typedef logic [3:0][15:0] t_quad_addr;

    logic                       i_clk   = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       psel    = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite  = 1'b0;
    logic [brs_pkg::APB_AW-1:0] paddr   = '0;
    logic [brs_pkg::APB_DW-1:0] pwdata  = '0;
    logic [brs_pkg::APB_DW-1:0] prdata;
    logic                       pready;
    logic                       rx_ready = 1'b0;

    brs_in_if  req_if ();
    brs_out_if res_if ();

    assign res_if.ready = rx_ready;

    bilinear_rgb_sampler_top #(
        .IMG_COLS  (IMG_COLS),
        .IMG_ROWS  (IMG_ROWS),
        .FRAC_BITS (FRAC_BITS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (req_if),
        .o_out   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // local image copy and size shadow
    t_rgb           img_mem     [IMG_COLS*IMG_ROWS];
    bit             img_written [IMG_COLS*IMG_ROWS];
    brs_pkg::t_size cfg_width  = 9'd256;
    brs_pkg::t_size cfg_height = 9'd256;

    t_rgb rgb_expect_q [$];
    int   fail_count    = 0;
    int   words_sent    = 0;
    bit   tx_gaps_on    = 1'b1;
    bit   rx_stalls_on  = 1'b1;
    int   rx_hold_req   = 0;
    int   rx_stall_left = 0;
    int   stuck_cycles  = 0;

    always #(CLK_HALF) i_clk = ~i_clk;

    function automatic int unsigned eff_size(brs_pkg::t_size v, int unsigned limit);
        if (v == 0) return 1;
        if (v > limit) return limit;
        return v;
    endfunction

    function automatic brs_pkg::t_coord clip_coord(int unsigned v);
        return (v > 255) ? 8'd255 : brs_pkg::t_coord'(v);
    endfunction

    function automatic logic [FRAC_BITS-1:0] pick_frac();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return FRAC_BITS'(1 << (FRAC_BITS - 1));
            2: return '1;
            default: return FRAC_BITS'($urandom());
        endcase
    endfunction

    // neighbour store addresses in the order 00, 10, 01, 11, clamped to the size in use
    function automatic t_quad_addr neighbour_addrs(brs_pkg::t_pos xp, brs_pkg::t_pos yp);
        int unsigned last_c, last_r, c, r, c0, c1, r0, r1;
        t_quad_addr q;
        last_c = eff_size(cfg_width, IMG_COLS) - 1;
        last_r = eff_size(cfg_height, IMG_ROWS) - 1;
        c  = int'(xp) >> FRAC_BITS;
        r  = int'(yp) >> FRAC_BITS;
        c0 = (c > last_c) ? last_c : c;
        c1 = (c + 1 > last_c) ? last_c : c + 1;
        r0 = (r > last_r) ? last_r : r;
        r1 = (r + 1 > last_r) ? last_r : r + 1;
        q[0] = 16'(r0 * IMG_COLS + c0);
        q[1] = 16'(r0 * IMG_COLS + c1);
        q[2] = 16'(r1 * IMG_COLS + c0);
        q[3] = 16'(r1 * IMG_COLS + c1);
        return q;
    endfunction

    function automatic t_rgb blend_rgb(brs_pkg::t_pos xp, brs_pkg::t_pos yp);
        t_quad_addr  q;
        logic [23:0] p [4];
        logic [7:0]  lanes [3];
        int unsigned fx, fy, a, b, d, e, top, bot, v;
        q  = neighbour_addrs(xp, yp);
        fx = int'(xp) & (SCALE - 1);
        fy = int'(yp) & (SCALE - 1);
        for (int k = 0; k < 4; k++) p[k] = img_mem[q[k]];
        for (int ch = 0; ch < 3; ch++) begin
            a   = p[0][23-8*ch -: 8];
            b   = p[1][23-8*ch -: 8];
            d   = p[2][23-8*ch -: 8];
            e   = p[3][23-8*ch -: 8];
            top = a * (SCALE - fx) + b * fx;
            bot = d * (SCALE - fx) + e * fx;
            v   = (top * (SCALE - fy) + bot * fy + HALF_LSB) >> (2 * FRAC_BITS);
            lanes[ch] = v[7:0];
        end
        return {lanes[0], lanes[1], lanes[2]};
    endfunction

    function automatic t_req_word random_word();
        t_req_word w;
        w.req_type  = 1'($urandom());
        w.pixel_col = brs_pkg::t_coord'($urandom());
        w.pixel_row = brs_pkg::t_coord'($urandom());
        w.pix       = t_rgb'(24'($urandom()));
        w.x_pos     = brs_pkg::t_pos'($urandom());
        w.y_pos     = brs_pkg::t_pos'($urandom());
        return w;
    endfunction

    // offer one word, hold it until taken, then update the image copy or queue the blend
    task automatic send_word(t_req_word w);
        int gap;
        gap = tx_gaps_on ? $urandom_range(0, 4) : 0;
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.req_type  <= w.req_type;
        req_if.pixel_col <= w.pixel_col;
        req_if.pixel_row <= w.pixel_row;
        req_if.in_red    <= w.pix.red;
        req_if.in_green  <= w.pix.green;
        req_if.in_blue   <= w.pix.blue;
        req_if.x_pos     <= w.x_pos;
        req_if.y_pos     <= w.y_pos;
        do @(posedge i_clk); while (req_if.ready !== 1'b1);
        words_sent++;
        if (w.req_type == brs_pkg::REQ_WRITE) begin
            if (w.pixel_col < IMG_COLS && w.pixel_row < IMG_ROWS) begin
                img_mem[int'(w.pixel_row) * IMG_COLS + w.pixel_col]     = w.pix;
                img_written[int'(w.pixel_row) * IMG_COLS + w.pixel_col] = 1'b1;
            end
        end else begin
            rgb_expect_q.push_back(blend_rgb(w.x_pos, w.y_pos));
        end
    endtask

    task automatic send_pixel(brs_pkg::t_coord col, brs_pkg::t_coord row, t_rgb pix);
        t_req_word w;
        w           = random_word();
        w.req_type  = brs_pkg::REQ_WRITE;
        w.pixel_col = col;
        w.pixel_row = row;
        w.pix       = pix;
        send_word(w);
    endtask

    task automatic send_sample(brs_pkg::t_pos xp, brs_pkg::t_pos yp);
        t_quad_addr q;
        t_req_word  w;
        q = neighbour_addrs(xp, yp);
        // write any neighbour never written so the read stays defined
        for (int k = 0; k < 4; k++) begin
            if (!img_written[q[k]])
                send_pixel(brs_pkg::t_coord'(q[k] % IMG_COLS),
                           brs_pkg::t_coord'(q[k] / IMG_COLS),
                           t_rgb'(24'($urandom())));
        end
        w          = random_word();
        w.req_type = brs_pkg::REQ_SAMPLE;
        w.x_pos    = xp;
        w.y_pos    = yp;
        send_word(w);
    endtask

    // drop valid, wait for every pending result, then let the pipeline empty
    task automatic drain();
        req_if.valid <= 1'b0;
        while (rgb_expect_q.size() != 0) @(posedge i_clk);
        repeat (PIPE_DEPTH + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, brs_pkg::t_size value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {23'($urandom()), value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        if (idx == brs_pkg::REG_WIDTH) cfg_width = value;
        else cfg_height = value;
    endtask

    task automatic set_size(brs_pkg::t_size w, brs_pkg::t_size h);
        drain();
        write_reg(brs_pkg::REG_WIDTH, w);
        write_reg(brs_pkg::REG_HEIGHT, h);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // extreme channel values, half-way rounding and the far corner of the store
    task automatic test_edges();
        send_pixel(8'd0, 8'd0, t_rgb'(24'h000000));
        send_pixel(8'd1, 8'd0, t_rgb'(24'hFFFFFF));
        send_pixel(8'd0, 8'd1, t_rgb'(24'hFF0080));
        send_pixel(8'd1, 8'd1, t_rgb'(24'h00FF7F));
        send_sample(16'h0000, 16'h0000);
        send_sample(16'h0080, 16'h0000);
        send_sample(16'h00FF, 16'h00FF);
        send_sample(16'h0080, 16'h0080);
        send_pixel(8'd255, 8'd255, t_rgb'(24'hFFFFFF));
        send_pixel(8'd254, 8'd255, t_rgb'(24'h010203));
        send_pixel(8'd255, 8'd254, t_rgb'(24'h808080));
        send_pixel(8'd254, 8'd254, t_rgb'(24'hFEFDFC));
        send_sample(16'hFFFF, 16'hFFFF);
        send_sample(16'hFE80, 16'hFFFF);
        send_sample(16'hFEFF, 16'hFE01);
        drain();
    endtask

    // zero and oversized sizes, a one-column image, and a write beyond the size in use
    task automatic test_size_registers();
        set_size(9'd0, 9'd0);
        send_sample(16'h1234, 16'h5678);
        send_sample(16'hFFFF, 16'h0000);
        set_size(9'd511, 9'd300);
        send_sample(16'hFFFF, 16'hFFFF);
        send_sample(16'hFF80, 16'hFF80);
        set_size(9'd1, 9'd256);
        send_sample(16'h0580, 16'h0080);
        set_size(9'd4, 9'd4);
        send_pixel(8'd200, 8'd3, t_rgb'(24'hAA550F));
        send_sample(16'h0380, 16'h0280);
        send_sample(16'h0140, 16'h00C0);
        set_size(9'd256, 9'd256);
        send_sample(16'hC800, 16'h0300);
        send_sample(16'hC7C0, 16'h0340);
        drain();
    endtask

    // stall the result side for a long stretch while words keep coming
    task automatic test_backpressure();
        set_size(9'd256, 9'd256);
        tx_gaps_on  = 1'b0;
        rx_hold_req = HOLD_CYCLES;
        repeat (60) begin
            if ($urandom_range(0, 3) == 0)
                send_pixel(clip_coord(100 + $urandom_range(0, 3)),
                           clip_coord(100 + $urandom_range(0, 3)),
                           t_rgb'(24'($urandom())));
            else
                send_sample({clip_coord(100 + $urandom_range(0, 2)), pick_frac()},
                            {clip_coord(100 + $urandom_range(0, 2)), pick_frac()});
        end
        tx_gaps_on = 1'b1;
        drain();
    endtask

    task automatic test_random_traffic();
        int unsigned eff_w, eff_h, wc, wr, stop_at;
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: set_size(9'd256, 9'd256);
                1: set_size(9'd1, 9'd1);
                2: set_size(9'd0, 9'd511);
                3: set_size(9'd256, 9'd1);
                4: set_size(9'd2, 9'd2);
                5: set_size(brs_pkg::t_size'($urandom_range(1, 16)),
                            brs_pkg::t_size'($urandom_range(1, 16)));
                default: set_size(brs_pkg::t_size'($urandom_range(0, 511)),
                                  brs_pkg::t_size'($urandom_range(0, 511)));
            endcase
            tx_gaps_on   = (p % 3 != 2);
            rx_stalls_on = (p % 4 != 1);
            eff_w   = eff_size(cfg_width, IMG_COLS);
            eff_h   = eff_size(cfg_height, IMG_ROWS);
            wc      = $urandom_range(0, eff_w - 1);
            wr      = $urandom_range(0, eff_h - 1);
            stop_at = words_sent + RANDOM_WORDS / PHASES;
            while (words_sent < stop_at) begin
                // move the working window now and then
                if ($urandom_range(0, 31) == 0) begin
                    wc = $urandom_range(0, eff_w - 1);
                    wr = $urandom_range(0, eff_h - 1);
                end
                if ($urandom_range(0, 9) < 3) begin
                    if ($urandom_range(0, 4) == 0)
                        send_pixel(brs_pkg::t_coord'($urandom()),
                                   brs_pkg::t_coord'($urandom()),
                                   t_rgb'(24'($urandom())));
                    else
                        send_pixel(clip_coord(wc + $urandom_range(0, 7)),
                                   clip_coord(wr + $urandom_range(0, 7)),
                                   t_rgb'(24'($urandom())));
                end else if ($urandom_range(0, 4) == 0) begin
                    send_sample(brs_pkg::t_pos'($urandom()), brs_pkg::t_pos'($urandom()));
                end else begin
                    send_sample({clip_coord(wc + $urandom_range(0, 9)), pick_frac()},
                                {clip_coord(wr + $urandom_range(0, 9)), pick_frac()});
                end
            end
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
        drain();
    endtask

    // result side: random stall after each word, or a long hold on request
    always @(posedge i_clk) begin
        if (rx_hold_req != 0) begin
            rx_stall_left = rx_hold_req;
            rx_hold_req   = 0;
        end else if (res_if.valid === 1'b1 && rx_ready) begin
            rx_stall_left = rx_stalls_on ? $urandom_range(0, 4) : 0;
        end else if (rx_stall_left != 0) begin
            rx_stall_left--;
        end
        rx_ready <= (rx_stall_left == 0);
    end

    always @(posedge i_clk) begin : result_check
        t_rgb want;
        if (i_rst_n && res_if.valid === 1'b1 && rx_ready) begin
            if (rgb_expect_q.size() == 0) begin
                $error("result word with no sample pending: %h%h%h",
                       res_if.out_red, res_if.out_green, res_if.out_blue);
                fail_count++;
            end else begin
                want = rgb_expect_q.pop_front();
                if (res_if.out_red !== want.red) begin
                    $error("out_red: expected %0d, actual %0d", want.red, res_if.out_red);
                    fail_count++;
                end
                if (res_if.out_green !== want.green) begin
                    $error("out_green: expected %0d, actual %0d", want.green,
                           res_if.out_green);
                    fail_count++;
                end
                if (res_if.out_blue !== want.blue) begin
                    $error("out_blue: expected %0d, actual %0d", want.blue, res_if.out_blue);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
            (res_if.valid === 1'b1 && rx_ready) ||
            (psel && penable && pwrite && pready === 1'b1)) begin
            stuck_cycles = 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            stuck_cycles++;
        end
    end

    initial begin
        req_if.valid     <= 1'b0;
        req_if.req_type  <= brs_pkg::REQ_WRITE;
        req_if.pixel_col <= '0;
        req_if.pixel_row <= '0;
        req_if.in_red    <= '0;
        req_if.in_green  <= '0;
        req_if.in_blue   <= '0;
        req_if.x_pos     <= '0;
        req_if.y_pos     <= '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_edges();
        test_size_registers();
        test_backpressure();
        test_random_traffic();
        drain();

        if (fail_count == 0 && rgb_expect_q.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
